>>> src/mict_pkg.sv
// Package with the shared types, codes and sizes of the multiset intersection count table.
package mict_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 64;
    localparam int COUNT_BITS    = 8;
    localparam int KEY_BITS      = 32;
    localparam int CMD_BITS      = 2;
    localparam int STATUS_BITS   = 3;

    // Command codes of an input item.
    localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_PROBE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

    // Status codes of a result item.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_LOADED    = 3'd0,
        ST_FULL      = 3'd1,
        ST_SATURATED = 3'd2,
        ST_MATCH     = 3'd3,
        ST_NOMATCH   = 3'd4,
        ST_CLEARED   = 3'd5
    } t_status;

    // Update request broadcast from the top level to every table entry.
    typedef struct packed {
        logic                load;
        logic                probe;
        logic                clear;
        logic [KEY_BITS-1:0] key;
    } t_entry_ctl;

endpackage

>>> src/mict_entry.sv
// One table entry: stored key and count, key compare and count update.
module mict_entry
    import mict_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry_ctl i_ctl,
    input  logic       i_take_free,
    output logic       o_hit,
    output logic       o_free,
    output logic       o_at_max
);

    logic [KEY_BITS-1:0]   r_key;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;

    // An entry is live while its count is above zero; only live keys compare.
    assign o_free   = (r_count == '0);
    assign o_hit    = !o_free && (r_key == i_ctl.key);
    assign o_at_max = &r_count;

    // Count update for clear, new key, load hit and probe hit.
    always_comb begin
        n_count = r_count;
        if (i_ctl.clear) begin
            n_count = '0;
        end else if (i_take_free) begin
            n_count = COUNT_BITS'(1);
        end else if (o_hit && i_ctl.load && !o_at_max) begin
            n_count = r_count + COUNT_BITS'(1);
        end else if (o_hit && i_ctl.probe) begin
            n_count = r_count - COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // The key is written when this entry takes a new key.
    always_ff @(posedge i_clk) begin
        if (i_take_free) begin
            r_key <= i_ctl.key;
        end
    end

endmodule

>>> src/multiset_intersect_count_table.sv
// Top level of the multiset intersection count table.
// This block takes one item per clock cycle while its output is not stalled, and returns one result
// item for each. The item sits in an input register, the key is compared against all table entries
// at once, and the table update and the result register are written at the same edge, so the next
// item already sees the updated table. The compare runs in parallel across every entry. Load items
// add a key to the table, probe items consume one copy of a key and report a match, and clear items
// empty the whole table at once. Counts reset to zero with the block, so no clearing pass follows
// reset.
module multiset_intersect_count_table
    import mict_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [CMD_BITS-1:0]        i_cmd,
    input  logic signed [KEY_BITS-1:0] i_element_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [STATUS_BITS-1:0]     o_status,
    output logic signed [KEY_BITS-1:0] o_result_value
);

    logic                r_in_valid;
    logic [CMD_BITS-1:0] r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic                r_out_valid;
    t_status             r_status;
    t_status             n_status;
    logic [KEY_BITS-1:0] r_value;
    logic [KEY_BITS-1:0] n_value;

    logic                     w_out_adv;
    logic                     w_process;
    t_entry_ctl               w_ctl;
    logic [TABLE_ENTRIES-1:0] w_hit;
    logic [TABLE_ENTRIES-1:0] w_free;
    logic [TABLE_ENTRIES-1:0] w_at_max;
    logic [TABLE_ENTRIES-1:0] w_first_free;
    logic [TABLE_ENTRIES-1:0] w_take_free;
    logic                     w_any_hit;
    logic                     w_full;
    logic                     w_hit_at_max;

    // The item in the input register moves on when the result register is empty or drained.
    assign w_out_adv  = !r_out_valid || i_out_ready;
    assign w_process  = r_in_valid && w_out_adv;
    assign o_in_ready = !r_in_valid || w_out_adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd <= i_cmd;
            r_key <= $unsigned(i_element_value);
        end
    end

    // Update request for the table, gated by the item actually moving on.
    assign w_ctl.load  = w_process && (r_cmd == CMD_LOAD);
    assign w_ctl.probe = w_process && (r_cmd == CMD_PROBE);
    assign w_ctl.clear = w_process && (r_cmd == CMD_CLEAR);
    assign w_ctl.key   = r_key;

    // Table lookup summary; live keys are unique, so at most one entry hits.
    assign w_any_hit    = |w_hit;
    assign w_hit_at_max = |(w_hit & w_at_max);
    assign w_full       = (w_free == '0);

    // Lowest free entry as a one-hot vector, taken only by a load of a new key.
    assign w_first_free = w_free & (~w_free + TABLE_ENTRIES'(1));
    assign w_take_free  = w_ctl.load && !w_any_hit ? w_first_free : '0;

    // Table entries.
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_entry
        mict_entry u_entry (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_take_free (w_take_free[g]),
            .o_hit       (w_hit[g]),
            .o_free      (w_free[g]),
            .o_at_max    (w_at_max[g])
        );
    end

    // Result of the item in the input register.
    always_comb begin
        n_value = r_key;
        case (r_cmd)
            CMD_LOAD: begin
                if (w_any_hit) begin
                    n_status = w_hit_at_max ? ST_SATURATED : ST_LOADED;
                end else begin
                    n_status = w_full ? ST_FULL : ST_LOADED;
                end
            end
            CMD_PROBE: begin
                n_status = w_any_hit ? ST_MATCH : ST_NOMATCH;
            end
            CMD_CLEAR: begin
                n_status = ST_CLEARED;
                n_value  = '0;
            end
            default: begin
                n_status = ST_NOMATCH;
            end
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_process) begin
            r_status <= n_status;
            r_value  <= n_value;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_result_value = $signed(r_value);

endmodule

>>> src/mict_checker.sv
// Port-level checker of the multiset intersection count table, with its bind statement.
module mict_checker
    import mict_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic [CMD_BITS-1:0]        i_cmd,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [STATUS_BITS-1:0]     o_status,
    input logic signed [KEY_BITS-1:0] o_result_value
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // With no result waiting, the block always takes a new item.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready while output is empty");

    // A clear result always carries the value zero.
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_CLEARED) |-> (o_result_value == '0))
        else $error("clear result with nonzero value");

    // An accepted clear with the output free comes out as a clear result.
    a_clear_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_cmd == CMD_CLEAR) && !o_out_valid
        ##1 (!o_out_valid || i_out_ready)
        |=> o_out_valid && (o_status == ST_CLEARED))
        else $error("clear item lost or mislabeled");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_result_value))
        else $error("stalled result changed");

endmodule

bind multiset_intersect_count_table mict_checker u_mict_checker (.*);
